/* hw/rtl/tcpq_pkg.sv */
// Shared types, constants and helpers for the two-class priority queue.
package tcpq_pkg;

    localparam int DEPTH     = 16;
    localparam int DATA_BITS = 32;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CMP_W     = CNT_W + 4;

    localparam logic [1:0] FN_ENQ  = 2'd0;
    localparam logic [1:0] FN_DEQ  = 2'd1;
    localparam logic [1:0] FN_READ = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [DATA_BITS-1:0] data;
        logic                 pri;
    } entry_t;

    typedef enum logic [1:0] {
        SH_HOLD   = 2'd0,
        SH_INSERT = 2'd1,
        SH_POP    = 2'd2
    } shift_op_t;

    typedef struct packed {
        shift_op_t        op;
        logic [IDX_W-1:0] pos;
    } shift_ctl_t;

    function automatic logic [DATA_BITS-1:0] port_to_data(input logic [31:0] p);
        logic [63:0] w;
        w = 64'(p);
        return w[DATA_BITS-1:0];
    endfunction

    function automatic logic [31:0] data_to_port(input logic [DATA_BITS-1:0] d);
        logic [63:0] w;
        w = 64'(d);
        return w[31:0];
    endfunction

endpackage

/* hw/rtl/tcpq_cell.sv */
// One queue slot: holds, takes the new entry, or shifts from a neighbor.
module tcpq_cell (
    input  logic                      aclk,
    input  logic [tcpq_pkg::IDX_W-1:0] cell_idx,
    input  tcpq_pkg::shift_ctl_t      ctl,
    input  tcpq_pkg::entry_t          new_entry,
    input  tcpq_pkg::entry_t          left_entry,
    input  tcpq_pkg::entry_t          right_entry,
    output tcpq_pkg::entry_t          entry
);
    import tcpq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        case (ctl.op)
            SH_INSERT: begin
                if (cell_idx == ctl.pos) begin
                    entry_next = new_entry;
                end else if (cell_idx > ctl.pos) begin
                    entry_next = left_entry;
                end
            end
            SH_POP: begin
                entry_next = right_entry;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

/* hw/rtl/tcpq_row.sv */
// Chain of queue cells with head tap and indexed read select.
module tcpq_row (
    input  logic                 aclk,
    input  tcpq_pkg::shift_ctl_t ctl,
    input  tcpq_pkg::entry_t     new_entry,
    input  logic [3:0]           rd_index,
    output tcpq_pkg::entry_t     head_entry,
    output tcpq_pkg::entry_t     rd_entry
);
    import tcpq_pkg::*;

    entry_t cells [DEPTH];

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        entry_t left_e;
        entry_t right_e;
        if (k == 0) begin : g_first
            assign left_e = new_entry;
        end else begin : g_mid_l
            assign left_e = cells[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign right_e = cells[k];
        end else begin : g_mid_r
            assign right_e = cells[k+1];
        end
        tcpq_cell u_cell (
            .aclk        (aclk),
            .cell_idx    (IDX_W'(k)),
            .ctl         (ctl),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (cells[k])
        );
    end

    assign head_entry = cells[0];

    always_comb begin
        rd_entry = '0;
        for (int k = 0; k < DEPTH; k++) begin
            if (CMP_W'(k) == CMP_W'(rd_index)) begin
                rd_entry = rd_entry | cells[k];
            end
        end
    end

endmodule

/* hw/rtl/two_class_priority_queue_top.sv */
// Top level of the two-class priority queue: counters, cell chain, result register.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_func s_is_priority s_payload s_index
//  m_      | out       | m_valid / m_ready  | m_status m_entry_data m_entry_priority
//          |           |                    | m_occupancy
//
// Every operation completes in the cycle of its transfer; the result is registered.
// Throughput is one item per cycle unless stalled: each op is a single shift of the
// cell chain or a select over it. s_ready drops only while a result waits with
// m_ready low. Reset clears the counts and the result valid; slots are not cleared.
module two_class_priority_queue_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic        s_is_priority,
    input  logic [31:0] s_payload,
    input  logic [3:0]  s_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_entry_data,
    output logic        m_entry_priority,
    output logic [4:0]  m_occupancy
);
    import tcpq_pkg::*;

    logic [CNT_W-1:0] held_reg, held_next;
    logic [CNT_W-1:0] prio_reg, prio_next;
    logic             m_valid_reg, m_valid_next;
    logic [1:0]       status_reg, status_next;
    logic [31:0]      data_reg, data_next;
    logic             pri_reg, pri_next;
    logic [4:0]       occ_reg, occ_next;

    shift_ctl_t ctl;
    entry_t     new_entry;
    entry_t     head_entry;
    entry_t     rd_entry;
    logic       xfer_in;

    assign s_ready = !m_valid_reg || m_ready;
    assign xfer_in = s_valid && s_ready;

    assign new_entry.data = port_to_data(s_payload);
    assign new_entry.pri  = s_is_priority;

    tcpq_row u_row (
        .aclk       (aclk),
        .ctl        (ctl),
        .new_entry  (new_entry),
        .rd_index   (s_index),
        .head_entry (head_entry),
        .rd_entry   (rd_entry)
    );

    always_comb begin
        held_next    = held_reg;
        prio_next    = prio_reg;
        ctl.op       = SH_HOLD;
        ctl.pos      = '0;
        status_next  = status_reg;
        data_next    = data_reg;
        pri_next     = pri_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (xfer_in) begin
            m_valid_next = 1'b1;
            status_next  = ST_OK;
            data_next    = '0;
            pri_next     = 1'b0;
            case (s_func)
                FN_ENQ: begin
                    if (held_reg == CNT_W'(DEPTH)) begin
                        status_next = ST_FULL;
                    end else begin
                        ctl.op    = SH_INSERT;
                        // priority entries go right behind the last priority entry
                        ctl.pos   = s_is_priority ? IDX_W'(prio_reg) : IDX_W'(held_reg);
                        held_next = held_reg + CNT_W'(1);
                        prio_next = prio_reg + CNT_W'(s_is_priority);
                    end
                end
                FN_DEQ: begin
                    if (held_reg == '0) begin
                        status_next = ST_EMPTY;
                    end else begin
                        ctl.op    = SH_POP;
                        data_next = data_to_port(head_entry.data);
                        pri_next  = head_entry.pri;
                        held_next = held_reg - CNT_W'(1);
                        if (head_entry.pri && prio_reg != '0) begin
                            prio_next = prio_reg - CNT_W'(1);
                        end
                    end
                end
                FN_READ: begin
                    if (CMP_W'(s_index) >= CMP_W'(held_reg)) begin
                        status_next = ST_EMPTY;
                    end else begin
                        data_next = data_to_port(rd_entry.data);
                        pri_next  = rd_entry.pri;
                    end
                end
                default: begin
                    status_next = ST_OK;
                end
            endcase
        end
        occ_next = xfer_in ? 5'(held_next) : occ_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg    <= '0;
            prio_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            held_reg    <= held_next;
            prio_reg    <= prio_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        data_reg   <= data_next;
        pri_reg    <= pri_next;
        occ_reg    <= occ_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_entry_data     = data_reg;
    assign m_entry_priority = pri_reg;
    assign m_occupancy      = occ_reg;

endmodule

/* hw/rtl/tcpq_checker.sv */
// Port-level checks for the two-class priority queue, bound to the top level.
module tcpq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [31:0] m_entry_data,
    input logic        m_entry_priority,
    input logic [4:0]  m_occupancy
);
    import tcpq_pkg::*;

    // a stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_entry_data)
            && $stable(m_entry_priority) && $stable(m_occupancy))
        else $error("result changed while stalled");

    // input side never blocks when no result is pending
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with no pending result");

    // a dropped enqueue only happens at capacity
    a_full_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> m_occupancy == 5'(DEPTH))
        else $error("full status below capacity");

    // empty or out-of-range results carry no entry
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_EMPTY |-> m_entry_data == '0 && !m_entry_priority)
        else $error("empty status with nonzero entry");

endmodule

bind two_class_priority_queue_top tcpq_checker u_tcpq_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_entry_data     (m_entry_data),
    .m_entry_priority (m_entry_priority),
    .m_occupancy      (m_occupancy)
);

/* tb/tcpq_checker.sv */
// Checker for the two-class priority queue: shadow queue, reply prediction and comparison.
`timescale 1ns / 100ps

module tcpq_tb_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic        s_is_priority,
    input  logic [31:0] s_payload,
    input  logic [3:0]  s_index,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [31:0] m_entry_data,
    input  logic        m_entry_priority,
    input  logic [4:0]  m_occupancy,
    output int          fail_count,
    output int          replies_due
);
    import tcpq_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data;
        logic        pri;
        logic [4:0]  occ;
    } reply_t;

    // shadow copy of the slot chain; head at index 0
    entry_t shadow_slot [DEPTH];
    int     shadow_held;
    int     shadow_prio;
    reply_t awaited_replies [$];
    int     mismatches = 0;

    initial begin
        fail_count  = 0;
        replies_due = 0;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("%0t tcpq_checker: %s got %h want %h", $time, field, got, want);
    endtask

    task automatic step_shadow_queue(input logic [1:0] fn, input logic cls,
                                     input logic [31:0] word, input logic [3:0] pos,
                                     output reply_t r);
        int     at;
        entry_t head;
        r = '0;
        case (fn)
            FN_ENQ: begin
                if (shadow_held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // priority entries go in behind the last priority entry
                    at = cls ? shadow_prio : shadow_held;
                    for (int k = shadow_held; k > at; k--)
                        shadow_slot[k] = shadow_slot[k-1];
                    shadow_slot[at].data = DATA_BITS'(word);
                    shadow_slot[at].pri  = cls;
                    shadow_held++;
                    if (cls)
                        shadow_prio++;
                    r.status = ST_OK;
                end
            end
            FN_DEQ: begin
                if (shadow_held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    head = shadow_slot[0];
                    if (head.pri && shadow_prio > 0)
                        shadow_prio--;
                    for (int k = 0; k + 1 < shadow_held; k++)
                        shadow_slot[k] = shadow_slot[k+1];
                    shadow_held--;
                    r.status = ST_OK;
                    r.data   = 32'(head.data);
                    r.pri    = head.pri;
                end
            end
            FN_READ: begin
                if (int'(pos) >= shadow_held) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.status = ST_OK;
                    r.data   = 32'(shadow_slot[pos].data);
                    r.pri    = shadow_slot[pos].pri;
                end
            end
            default: begin
                r.status = ST_OK;
            end
        endcase
        r.occ = 5'(shadow_held);
    endtask

    // outputs are compared before the same-edge input transfer is predicted:
    // a reply never leaves in the cycle of its own transfer
    always @(posedge aclk) begin
        reply_t next_reply;
        if (!aresetn) begin
            awaited_replies.delete();
            shadow_held = 0;
            shadow_prio = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (awaited_replies.size() == 0) begin
                    report_mismatch("reply with none awaited", m_entry_data, '0);
                end else begin
                    next_reply = awaited_replies.pop_front();
                    if (m_status !== next_reply.status)
                        report_mismatch("status", 32'(m_status), 32'(next_reply.status));
                    if (m_entry_data !== next_reply.data)
                        report_mismatch("entry_data", m_entry_data, next_reply.data);
                    if (m_entry_priority !== next_reply.pri)
                        report_mismatch("entry_priority", 32'(m_entry_priority),
                                        32'(next_reply.pri));
                    if (m_occupancy !== next_reply.occ)
                        report_mismatch("occupancy", 32'(m_occupancy), 32'(next_reply.occ));
                end
            end
            if (s_valid && s_ready) begin
                step_shadow_queue(s_func, s_is_priority, s_payload, s_index, next_reply);
                awaited_replies.push_back(next_reply);
            end
        end
        fail_count  <= mismatches;
        replies_due <= awaited_replies.size();
    end

endmodule

/* tb/tb_top.sv */
// Testbench top for the two-class priority queue: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import tcpq_pkg::*;

    localparam logic [1:0] FN_NONE = 2'd3;   // unused code, must act as a no-op
    localparam int ITEM_GOAL      = 700;
    localparam int CALM_FROM      = 600;     // no idling on either side past this
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {SEQ_FILL, SEQ_DRAIN, SEQ_SCAN, SEQ_MIX} seq_kind_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = FN_ENQ;
    logic        s_is_priority = 1'b0;
    logic [31:0] s_payload = '0;
    logic [3:0]  s_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b1;
    logic [1:0]  m_status;
    logic [31:0] m_entry_data;
    logic        m_entry_priority;
    logic [4:0]  m_occupancy;

    int fail_count;
    int replies_due;
    int items_sent = 0;
    int occ_guess = 0;      // rough occupancy, only to shape sequences
    int gap_odds = 0;       // 0: no sender gaps, else one gap in gap_odds items
    int stall_odds = 0;     // 0: no receiver stalls, else one stall per stall_odds cycles
    int stall_left = 0;
    int quiet_cycles = 0;

    always #5 aclk = ~aclk;

    two_class_priority_queue_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_is_priority    (s_is_priority),
        .s_payload        (s_payload),
        .s_index          (s_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_entry_data     (m_entry_data),
        .m_entry_priority (m_entry_priority),
        .m_occupancy      (m_occupancy)
    );

    tcpq_tb_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_func           (s_func),
        .s_is_priority    (s_is_priority),
        .s_payload        (s_payload),
        .s_index          (s_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_entry_data     (m_entry_data),
        .m_entry_priority (m_entry_priority),
        .m_occupancy      (m_occupancy),
        .fail_count       (fail_count),
        .replies_due      (replies_due)
    );

    // receiver stalls come in bursts of random length
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
            stall_left = $urandom_range(0, 12);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("[two_class_priority_queue_top] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 8;
            default: return 3;
        endcase
    endfunction

    // called at a clock edge; returns at the edge of the transfer
    task automatic send_op(input logic [1:0] fn, input logic cls, input logic [31:0] word,
                           input logic [3:0] pos);
        int gap;
        gap = 0;
        if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
            gap = $urandom_range(1, 13);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= fn;
        s_is_priority <= cls;
        s_payload     <= word;
        s_index       <= pos;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (fn == FN_ENQ && occ_guess < DEPTH)
            occ_guess++;
        else if (fn == FN_DEQ && occ_guess > 0)
            occ_guess--;
    endtask

    task automatic send_random_op();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)
            send_op(FN_ENQ, 1'($urandom), rand_word(), 4'($urandom));
        else if (r < 14)
            send_op(FN_DEQ, 1'($urandom), rand_word(), 4'($urandom));
        else if (r < 19)
            send_op(FN_READ, 1'($urandom), rand_word(), 4'($urandom_range(0, 15)));
        else
            send_op(FN_NONE, 1'($urandom), rand_word(), 4'($urandom));
    endtask

    initial begin
        seq_kind_t kind;
        int        seq_no;
        int        n;

        repeat (7) @(posedge aclk);
        aresetn    <= 1'b1;
        gap_odds   = 4;
        stall_odds = 4;

        // empty queue corner cases
        send_op(FN_DEQ, 1'b1, 32'hDEAD_BEEF, 4'd0);
        send_op(FN_READ, 1'b0, '0, 4'd0);
        send_op(FN_NONE, 1'b1, '1, 4'd15);
        // two normal, then two priority entries that must jump ahead
        send_op(FN_ENQ, 1'b0, '0, 4'd0);
        send_op(FN_ENQ, 1'b0, '1, 4'd15);
        send_op(FN_ENQ, 1'b1, 32'hA5A5_A5A5, 4'd0);
        send_op(FN_ENQ, 1'b1, 32'h5A5A_5A5A, 4'd0);
        for (int i = 0; i < 5; i++)
            send_op(FN_READ, 1'b0, '0, 4'(i));
        send_op(FN_READ, 1'b1, '1, 4'd15);
        send_op(FN_NONE, 1'b0, '0, 4'd0);
        send_op(FN_DEQ, 1'b0, '0, 4'd0);
        send_op(FN_DEQ, 1'b0, '0, 4'd0);
        send_op(FN_DEQ, 1'b0, '0, 4'd0);
        // priority entry behind normal entries must go to the head
        send_op(FN_ENQ, 1'b1, 32'h8000_0001, 4'd0);
        send_op(FN_READ, 1'b0, '0, 4'd0);
        send_op(FN_DEQ, 1'b0, '0, 4'd0);
        send_op(FN_DEQ, 1'b0, '0, 4'd0);
        send_op(FN_DEQ, 1'b0, '0, 4'd0);

        seq_no = 0;
        while (items_sent < ITEM_GOAL) begin
            if (items_sent >= CALM_FROM) begin
                gap_odds   = 0;
                stall_odds = 0;
            end else begin
                gap_odds   = pick_odds();
                stall_odds = pick_odds();
            end
            if (seq_no == 0)
                kind = SEQ_FILL;
            else if (seq_no == 1)
                kind = SEQ_DRAIN;
            else
                case ($urandom_range(0, 4))
                    0:       kind = SEQ_FILL;
                    1:       kind = SEQ_DRAIN;
                    2:       kind = SEQ_SCAN;
                    default: kind = SEQ_MIX;
                endcase
            case (kind)
                SEQ_FILL: begin
                    // run past full so the drop path is hit, then read the tail slot
                    n = DEPTH - occ_guess + $urandom_range(1, 2);
                    repeat (n)
                        send_op(FN_ENQ, 1'($urandom), rand_word(), 4'($urandom));
                    send_op(FN_READ, 1'($urandom), rand_word(), 4'(DEPTH - 1));
                end
                SEQ_DRAIN: begin
                    n = occ_guess + $urandom_range(1, 2);
                    repeat (n)
                        send_op(FN_DEQ, 1'($urandom), rand_word(), 4'($urandom));
                end
                SEQ_SCAN: begin
                    for (int i = 0; i < DEPTH; i++)
                        send_op(FN_READ, 1'($urandom), rand_word(), 4'(i));
                end
                default: begin
                    repeat (24)
                        send_random_op();
                end
            endcase
            seq_no++;
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (replies_due != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (fail_count == 0)
            $display("[two_class_priority_queue_top] OK");
        else
            $display("[two_class_priority_queue_top] ERROR");
        $finish;
    end

endmodule
